// File: hw/rtl/mwrpm_pkg.sv
// Shared constants, types and helpers of the multi-window rpm estimator.
package mwrpm_pkg;

    // Sample ring; its depth must be a power of two (index wraps by truncation).
    localparam int RING_DEPTH = 128;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam int NUM_WIN   = 4;
    localparam int WIN_W     = $clog2(NUM_WIN);
    localparam int WIN_LEN_W = 7;
    localparam int TAIL_CALC_W = (RING_AW > WIN_LEN_W) ? RING_AW : WIN_LEN_W;

    localparam int DATA_W  = 32;
    localparam int RPM_W   = 16;
    localparam int MINP_W  = 16;
    localparam int PPR_W   = 8;
    localparam int PROD_W  = DATA_W + RPM_W;

    localparam logic [DATA_W-1:0] RPM_NUMERATOR = DATA_W'(60000);
    localparam logic [RPM_W-1:0]  RPM_MAX       = '1;

    // Shared divider retires two quotient bits per cycle.
    localparam int DIV_STEPS = DATA_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // APB register map
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int PADDR_W   = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_WIN_A      = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_WIN_B      = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_WIN_C      = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_WIN_D      = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_PPR        = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_PULSE_WRAP = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_TIME_WRAP  = REG_IDX_W'(7);

    typedef struct packed {
        logic [NUM_WIN-1:0][WIN_LEN_W-1:0] win_len;
        logic [MINP_W-1:0]                 min_pulse;
        logic [PPR_W-1:0]                  ppr;
        logic [DATA_W-1:0]                 pulse_wrap;
        logic [DATA_W-1:0]                 time_wrap;
    } mwrpm_cfg_t;

    localparam mwrpm_cfg_t CFG_RESET = '{
        win_len:    {WIN_LEN_W'(100), WIN_LEN_W'(50), WIN_LEN_W'(10), WIN_LEN_W'(1)},
        min_pulse:  MINP_W'(1),
        ppr:        PPR_W'(1),
        pulse_wrap: '1,
        time_wrap:  '1
    };

    // Controller to datapath commands
    typedef struct packed {
        logic             load_in;
        logic             div_start;
        logic             div_sel_k;
        logic             div_step;
        logic             k_save;
        logic             rd_tail;
        logic             diff;
        logic             mul;
        logic             res_set;
        logic             out_load;
        logic [WIN_W-1:0] win;
    } mwrpm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic win_ok;
        logic prod_nz;
        logic out_free;
    } mwrpm_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KDIV,
        ST_KSAVE,
        ST_READ,
        ST_DIFF,
        ST_CHECK,
        ST_WDIV,
        ST_MUL,
        ST_PICK,
        ST_DONE
    } mwrpm_state_t;

    // Counter difference that wraps at a modulus; zero when the old value
    // lies above the modulus plus the new value.
    function automatic logic [DATA_W-1:0] wrap_diff(
        input logic [DATA_W-1:0] now_val,
        input logic [DATA_W-1:0] prev_val,
        input logic [DATA_W-1:0] wrap
    );
        logic [DATA_W+1:0] d;
        d = {2'b00, wrap} - {2'b00, prev_val} + {2'b00, now_val};
        if (now_val >= prev_val)
            return now_val - prev_val;
        return d[DATA_W+1] ? '0 : d[DATA_W-1:0];
    endfunction

endpackage

// File: hw/rtl/mwrpm_regs.sv
// APB configuration registers of the multi-window rpm estimator.
module mwrpm_regs
    import mwrpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output mwrpm_cfg_t         cfg
);

    mwrpm_cfg_t             cfg_reg;
    mwrpm_cfg_t             cfg_next;
    logic [REG_IDX_W-1:0]   idx;
    logic                   wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_WIN_A:      cfg_next.win_len[0] = pwdata[WIN_LEN_W-1:0];
                REG_WIN_B:      cfg_next.win_len[1] = pwdata[WIN_LEN_W-1:0];
                REG_WIN_C:      cfg_next.win_len[2] = pwdata[WIN_LEN_W-1:0];
                REG_WIN_D:      cfg_next.win_len[3] = pwdata[WIN_LEN_W-1:0];
                REG_MIN_PULSE:  cfg_next.min_pulse  = pwdata[MINP_W-1:0];
                REG_PPR:        cfg_next.ppr        = pwdata[PPR_W-1:0];
                REG_PULSE_WRAP: cfg_next.pulse_wrap = pwdata;
                REG_TIME_WRAP:  cfg_next.time_wrap  = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WIN_A:      prdata = DATA_W'(cfg_reg.win_len[0]);
            REG_WIN_B:      prdata = DATA_W'(cfg_reg.win_len[1]);
            REG_WIN_C:      prdata = DATA_W'(cfg_reg.win_len[2]);
            REG_WIN_D:      prdata = DATA_W'(cfg_reg.win_len[3]);
            REG_MIN_PULSE:  prdata = DATA_W'(cfg_reg.min_pulse);
            REG_PPR:        prdata = DATA_W'(cfg_reg.ppr);
            REG_PULSE_WRAP: prdata = cfg_reg.pulse_wrap;
            REG_TIME_WRAP:  prdata = cfg_reg.time_wrap;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

// File: hw/rtl/mwrpm_ctrl.sv
// Sequencing state machine of the multi-window rpm estimator.
module mwrpm_ctrl
    import mwrpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  mwrpm_sts_t sts,
    output mwrpm_cmd_t cmd
);

    mwrpm_state_t      state_reg;
    mwrpm_state_t      state_next;
    logic [WIN_W-1:0]  win_reg;
    logic [WIN_W-1:0]  win_next;
    logic              last_win;

    assign last_win = (win_reg == WIN_W'(NUM_WIN - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_KDIV;
            end
            ST_KDIV:
            begin
                if (sts.div_last)
                    state_next = ST_KSAVE;
            end
            ST_KSAVE: state_next = ST_READ;
            ST_READ:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (sts.win_ok)
                    state_next = ST_WDIV;
                else if (last_win)
                    state_next = ST_DONE;
                else
                begin
                    win_next   = win_reg + WIN_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_WDIV:
            begin
                if (sts.div_last)
                    state_next = ST_MUL;
            end
            ST_MUL:   state_next = ST_PICK;
            ST_PICK:
            begin
                if (sts.prod_nz || last_win)
                    state_next = ST_DONE;
                else
                begin
                    win_next   = win_reg + WIN_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    win_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                win_next   = '0;
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.win  = win_reg;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel_k = 1'b1;
                end
            end
            ST_KDIV:  cmd.div_step = 1'b1;
            ST_KSAVE: cmd.k_save   = 1'b1;
            ST_READ:  cmd.rd_tail  = 1'b1;
            ST_DIFF:  cmd.diff     = 1'b1;
            ST_CHECK: cmd.div_start = sts.win_ok;
            ST_WDIV:  cmd.div_step = 1'b1;
            ST_MUL:   cmd.mul      = 1'b1;
            ST_PICK:  cmd.res_set  = sts.prod_nz;
            ST_DONE:  cmd.out_load = sts.out_free;
            default:  cmd.win      = win_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            win_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
        end
    end

    a_accept_starts_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_KDIV))
        else $error("accepted item did not start the scale division");

    a_kdiv_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KDIV && sts.div_last) |=> (state_reg == ST_KSAVE))
        else $error("scale division did not end after its last step");

    a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && sts.out_free) |=> (state_reg == ST_IDLE && win_reg == '0))
        else $error("result handoff did not return to idle with window a");

endmodule

// File: hw/rtl/mwrpm_dp.sv
// Datapath of the multi-window rpm estimator: sample ring, differences,
// shared divider, multiplier and output register.
module mwrpm_dp
    import mwrpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mwrpm_cfg_t        cfg,
    input  mwrpm_cmd_t        cmd,
    output mwrpm_sts_t        sts,
    input  logic [DATA_W-1:0] time_ms,
    input  logic [DATA_W-1:0] pulse_total,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [RPM_W-1:0]  rpm
);

    logic [2*DATA_W-1:0]   ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] ring_vld_reg;
    logic [RING_DEPTH-1:0] ring_vld_next;
    logic [RING_AW-1:0]    head_reg;
    logic [RING_AW-1:0]    head_next;
    logic [RING_AW-1:0]    head_inc;
    logic [TAIL_CALC_W-1:0] tail_calc;
    logic [RING_AW-1:0]    tail_addr;

    logic [DATA_W-1:0]     time_reg;
    logic [DATA_W-1:0]     pulse_reg;
    logic [2*DATA_W-1:0]   rd_data_reg;
    logic                  rd_vld_reg;
    logic [DATA_W-1:0]     tail_time;
    logic [DATA_W-1:0]     tail_pulse;
    logic [DATA_W-1:0]     pd_reg;
    logic [DATA_W-1:0]     td_reg;

    logic [DATA_W-1:0]     rem_reg;
    logic [DATA_W-1:0]     rem_next;
    logic [DATA_W-1:0]     dq_reg;
    logic [DATA_W-1:0]     dq_next;
    logic [DATA_W-1:0]     dvs_reg;
    logic [DATA_W-1:0]     dvs_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_next;
    logic [DATA_W:0]       r1;
    logic [DATA_W:0]       r2;
    logic [DATA_W-1:0]     rem1;
    logic [DATA_W-1:0]     dq1;
    logic                  ge1;
    logic                  ge2;

    logic [RPM_W-1:0]      k_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [RPM_W-1:0]      res_reg;
    logic [RPM_W-1:0]      out_rpm_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // Ring pointers; depth is a power of two so indexes wrap by truncation
    assign head_inc  = head_reg + RING_AW'(1);
    assign tail_calc = TAIL_CALC_W'(head_reg) - TAIL_CALC_W'(cfg.win_len[cmd.win]);
    assign tail_addr = tail_calc[RING_AW-1:0];

    // Never-written entries read as zero
    assign tail_time  = rd_vld_reg ? rd_data_reg[DATA_W-1:0] : '0;
    assign tail_pulse = rd_vld_reg ? rd_data_reg[2*DATA_W-1:DATA_W] : '0;

    always_comb
    begin
        head_next     = head_reg;
        ring_vld_next = ring_vld_reg;
        if (cmd.load_in)
        begin
            head_next               = head_inc;
            ring_vld_next[head_inc] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            ring_mem[head_inc] <= {pulse_total, time_ms};
        if (cmd.rd_tail)
            rd_data_reg <= ring_mem[tail_addr];
    end

    // Restoring divider, two quotient bits per step
    always_comb
    begin
        r1   = {rem_reg, dq_reg[DATA_W-1]};
        ge1  = (r1 >= {1'b0, dvs_reg});
        rem1 = ge1 ? DATA_W'(r1 - {1'b0, dvs_reg}) : r1[DATA_W-1:0];
        dq1  = {dq_reg[DATA_W-2:0], ge1};
        r2   = {rem1, dq1[DATA_W-1]};
        ge2  = (r2 >= {1'b0, dvs_reg});

        rem_next     = rem_reg;
        dq_next      = dq_reg;
        dvs_next     = dvs_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.div_start)
        begin
            rem_next     = '0;
            dq_next      = cmd.div_sel_k ? RPM_NUMERATOR : pd_reg;
            dvs_next     = cmd.div_sel_k ? DATA_W'(cfg.ppr) : td_reg;
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next     = ge2 ? DATA_W'(r2 - {1'b0, dvs_reg}) : r2[DATA_W-1:0];
            dq_next      = {dq1[DATA_W-2:0], ge2};
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Output register frees when its item is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            ring_vld_reg  <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            ring_vld_reg  <= ring_vld_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
        if (cmd.load_in)
        begin
            time_reg  <= time_ms;
            pulse_reg <= pulse_total;
            res_reg   <= '0;
        end
        if (cmd.rd_tail)
            rd_vld_reg <= ring_vld_reg[tail_addr];
        if (cmd.diff)
        begin
            pd_reg <= wrap_diff(pulse_reg, tail_pulse, cfg.pulse_wrap);
            td_reg <= wrap_diff(time_reg, tail_time, cfg.time_wrap);
        end
        if (cmd.k_save)
            k_reg <= dq_reg[RPM_W-1:0];
        if (cmd.mul)
            prod_reg <= PROD_W'(dq_reg) * PROD_W'(k_reg);
        if (cmd.res_set)
            res_reg <= (prod_reg > PROD_W'(RPM_MAX)) ? RPM_MAX : prod_reg[RPM_W-1:0];
        if (cmd.out_load)
            out_rpm_reg <= res_reg;
    end

    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.win_ok   = (pd_reg >= DATA_W'(cfg.min_pulse)) && (td_reg != '0)
                          && (cfg.ppr != '0);
    assign sts.prod_nz  = (prod_reg != '0);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign rpm       = out_rpm_reg;

    a_head_written: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> ring_vld_reg[head_reg])
        else $error("new head entry not marked written");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over an item not yet taken");

endmodule

// File: hw/rtl/multi_window_rpm_estimator.sv
// Top level of the multi-window rpm estimator.
//
// Each input item is one 10 ms tick: a millisecond timestamp and the running
// Hall pulse count. The block advances its head pointer (the first item lands
// in entry 1 of a 128-entry sample ring), stores the pair there, and looks
// back window_len_a..d ticks. For each window it forms the pulse and time
// differences, wrapping at pulse_wrap and time_wrap, and when the pulse
// count reaches min_pulse_count, the time difference is nonzero and
// pulses_per_rev is nonzero, it computes (pulses / ms) * (60000 / pulses_per_rev)
// saturated to 65535. The result item carries the rpm of the first nonzero
// window in the order a, b, c, d, or 0. Ring entries never written read as
// zero. An item occupies the block from its acceptance until the next item
// can be taken, with the input stalled once the item is accepted. The
// shared two-bit-per-cycle divider sets this time: the item is accepted,
// the 60000 / pulses_per_rev scale is divided out and saved, then each
// window reads the ring and is tested, and each window that qualifies is
// divided, multiplied and picked, stopping at the first nonzero rpm; last,
// the result is handed off. A finished result waits in the output register,
// so the next item is taken while it is still held; the handoff stretches
// while an earlier result has not yet been taken.
// Registers sit at byte addresses 4*i on the APB port; writes are meant
// only while the block is idle.
module multi_window_rpm_estimator
    import mwrpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // Tick items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [DATA_W-1:0]  time_ms,
    input  logic [DATA_W-1:0]  pulse_total,
    // Result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic [RPM_W-1:0]   rpm
);

    mwrpm_cfg_t cfg;
    mwrpm_cmd_t cmd;
    mwrpm_sts_t sts;

    // Register file
    mwrpm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: scale division, then windows a to d
    mwrpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Ring, arithmetic and output register
    mwrpm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .time_ms     (time_ms),
        .pulse_total (pulse_total),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .rpm         (rpm)
    );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the multi-window rpm estimator: directed ticks, then random phases.
`timescale 1ns / 100ps

module testbench;
    import mwrpm_pkg::*;

    localparam int     HALF_PERIOD     = 4;
    localparam int     RESET_CYCLES    = 10;
    localparam int     PHASES          = 8;
    localparam int     TICKS_PER_PHASE = 150;
    localparam int     SETTLE_CYCLES   = 4;
    localparam int     TAIL_CYCLES     = 128;
    localparam int     PRINT_LIMIT     = 40;
    localparam int     SCRIPT_ROWS     = 23;
    localparam longint RUN_LIMIT_NS    = 20_000_000;

    localparam logic [DATA_W-1:0] RPM_SCALE = 32'd60000;
    localparam logic [RPM_W-1:0]  RPM_CEIL  = 16'hFFFF;

    // One line of the directed script: either a tick or a register write.
    typedef enum logic {
        ROW_TICK,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [REG_IDX_W-1:0] ridx;
        logic [DATA_W-1:0]    rval;
        logic [DATA_W-1:0]    t;
        logic [DATA_W-1:0]    p;
        logic                 chk;
        logic [RPM_W-1:0]     want;
    } script_row_t;

    // Clock and DUT ports
    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [DATA_W-1:0]  time_ms;
    logic [DATA_W-1:0]  pulse_total;
    logic               out_valid;
    logic               out_stall;
    logic [RPM_W-1:0]   rpm;

    // Shadow of the estimator: sample history, head pointer and register copies.
    logic [DATA_W-1:0]    hist_time  [RING_DEPTH];
    logic [DATA_W-1:0]    hist_pulse [RING_DEPTH];
    logic [RING_AW-1:0]   newest;
    logic [WIN_LEN_W-1:0] span [NUM_WIN];
    logic [MINP_W-1:0]    pulse_floor;
    logic [PPR_W-1:0]     pulses_rev;
    logic [DATA_W-1:0]    pulse_mod;
    logic [DATA_W-1:0]    time_mod;

    // rpm values owed by the block, oldest first
    logic [RPM_W-1:0] rpm_pending [$];

    int fail_count = 0;
    int idle_pct   = 0;   // chance of a gap or stall burst, both sides
    bit calm       = 1'b0; // no idling at all in the closing phase

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    multi_window_rpm_estimator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .time_ms     (time_ms),
        .pulse_total (pulse_total),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rpm         (rpm)
    );

    task automatic flag_error(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
        begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void clear_model();
        int i;
        for (i = 0; i < RING_DEPTH; i++)
        begin
            hist_time[i]  = '0;
            hist_pulse[i] = '0;
        end
        newest      = '0;
        span[0]     = 7'd1;
        span[1]     = 7'd10;
        span[2]     = 7'd50;
        span[3]     = 7'd100;
        pulse_floor = 16'd1;
        pulses_rev  = 8'd1;
        pulse_mod   = 32'hFFFF_FFFF;
        time_mod    = 32'hFFFF_FFFF;
    endfunction

    function automatic logic [DATA_W-1:0] reg_mask(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_WIN_A, REG_WIN_B, REG_WIN_C, REG_WIN_D: return 32'h0000_007F;
            REG_MIN_PULSE:                              return 32'h0000_FFFF;
            REG_PPR:                                    return 32'h0000_00FF;
            default:                                    return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic void store_setting(input logic [REG_IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] v);
        case (idx)
            REG_WIN_A:      span[0]     = v[WIN_LEN_W-1:0];
            REG_WIN_B:      span[1]     = v[WIN_LEN_W-1:0];
            REG_WIN_C:      span[2]     = v[WIN_LEN_W-1:0];
            REG_WIN_D:      span[3]     = v[WIN_LEN_W-1:0];
            REG_MIN_PULSE:  pulse_floor = v[MINP_W-1:0];
            REG_PPR:        pulses_rev  = v[PPR_W-1:0];
            REG_PULSE_WRAP: pulse_mod   = v;
            REG_TIME_WRAP:  time_mod    = v;
            default:        ;
        endcase
    endfunction

    // Counter difference across a wrap; an old value above the modulus plus the new one gives 0.
    function automatic logic [DATA_W-1:0] wrapped_gap(input logic [DATA_W-1:0] now_v,
                                                      input logic [DATA_W-1:0] then_v,
                                                      input logic [DATA_W-1:0] modulus);
        longint gap;
        if (now_v >= then_v)
            return now_v - then_v;
        gap = longint'({32'd0, modulus}) - longint'({32'd0, then_v})
            + longint'({32'd0, now_v});
        return (gap < 0) ? '0 : gap[DATA_W-1:0];
    endfunction

    // rpm seen over one window; the tail index wraps by truncation to the ring width.
    function automatic logic [RPM_W-1:0] span_rpm(input logic [WIN_LEN_W-1:0] len);
        logic [RING_AW-1:0] tail;
        logic [DATA_W-1:0]  dp;
        logic [DATA_W-1:0]  dt;
        logic [63:0]        v;
        tail = newest - RING_AW'(len);
        dp   = wrapped_gap(hist_pulse[newest], hist_pulse[tail], pulse_mod);
        dt   = wrapped_gap(hist_time[newest], hist_time[tail], time_mod);
        if (dp < {16'd0, pulse_floor} || dt == '0 || pulses_rev == '0)
            return '0;
        v = {32'd0, dp / dt} * {32'd0, RPM_SCALE / {24'd0, pulses_rev}};
        return (v > 64'(RPM_CEIL)) ? RPM_CEIL : v[RPM_W-1:0];
    endfunction

    // Store one tick and return the rpm of the first nonzero window, a first.
    function automatic logic [RPM_W-1:0] rpm_after_tick(input logic [DATA_W-1:0] t,
                                                        input logic [DATA_W-1:0] p);
        logic [RPM_W-1:0] best;
        logic [RPM_W-1:0] r;
        int               w;
        newest             = newest + 1'b1;
        hist_time[newest]  = t;
        hist_pulse[newest] = p;
        best               = '0;
        for (w = NUM_WIN - 1; w >= 0; w--)
        begin
            r = span_rpm(span[w]);
            if (r != '0)
                best = r;
        end
        return best;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Write a register (setup, then access), then read it back.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] kept;
        kept = value & reg_mask(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        store_setting(idx, value);
        // hold psel, drop to a read setup cycle
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== kept)
            flag_error($sformatf("register %0d reads 0x%08h, wrote 0x%08h", idx, prdata, kept));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one tick; on acceptance record what the block owes for it.
    // A typed value, where given, stands in for the prediction.
    task automatic send_tick(input logic [DATA_W-1:0] t, input logic [DATA_W-1:0] p,
                             input logic typed, input logic [RPM_W-1:0] want);
        int               gap;
        logic [RPM_W-1:0] predicted;
        if (!calm && $urandom_range(1, 100) <= idle_pct)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        time_ms     <= t;
        pulse_total <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = rpm_after_tick(t, p);
        rpm_pending.push_back(typed ? want : predicted);
    endtask

    // Drop valid, wait out every owed result, then give the block a few idle cycles.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (rpm_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] wrap_add(input logic [DATA_W-1:0] v,
                                                   input logic [DATA_W-1:0] inc,
                                                   input logic [DATA_W-1:0] modulus);
        logic [63:0] s;
        s = {32'd0, v} + {32'd0, inc};
        if (modulus == '0)
            return s[DATA_W-1:0];
        s = s % {32'd0, modulus};
        return s[DATA_W-1:0];
    endfunction

    // Starting count for a new run of ticks, often just below the wrap point.
    function automatic logic [DATA_W-1:0] start_point(input logic [DATA_W-1:0] modulus);
        if (modulus > 32'd400 && $urandom_range(0, 1) == 0)
            return modulus - $urandom_range(1, 400);
        if (modulus == '0)
            return $urandom;
        return $urandom % modulus;
    endfunction

    function automatic logic [WIN_LEN_W-1:0] pick_span();
        case ($urandom_range(0, 7))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd127;
            default: return WIN_LEN_W'($urandom_range(1, 127));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_modulus();
        case ($urandom_range(0, 3))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom_range(1000, 2_000_000);
            2:       return $urandom;
            default: return $urandom_range(1, 50);
        endcase
    endfunction

    // Program every register for one phase: two fixed corner settings, then random ones.
    task automatic apply_setting(input int phase);
        logic [DATA_W-1:0] v [NUM_REGS];
        int                r;
        if (phase == 0)
        begin
            v = '{32'd127, 32'd0, 32'd1, 32'd127, 32'd65535, 32'd1,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF};
        end
        else if (phase == 1)
        begin
            v = '{32'd1, 32'd127, 32'd0, 32'd64, 32'd0, 32'd255, 32'd1, 32'd1};
        end
        else
        begin
            for (r = 0; r < NUM_WIN; r++)
                v[r] = {25'd0, pick_span()};
            case ($urandom_range(0, 5))
                0:       v[REG_MIN_PULSE] = 32'd0;
                1:       v[REG_MIN_PULSE] = 32'd65535;
                2:       v[REG_MIN_PULSE] = $urandom_range(0, 65535);
                default: v[REG_MIN_PULSE] = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 9))
                0:       v[REG_PPR] = 32'd0;
                1:       v[REG_PPR] = 32'd1;
                2:       v[REG_PPR] = 32'd255;
                default: v[REG_PPR] = $urandom_range(1, 255);
            endcase
            v[REG_PULSE_WRAP] = pick_modulus();
            v[REG_TIME_WRAP]  = pick_modulus();
        end
        for (r = 0; r < NUM_REGS; r++)
            write_reg(REG_IDX_W'(r), v[r]);
    endtask

    // Mostly steady rotation: time advances about 10 ms a tick and the pulse
    // count at a segment rate, both wrapping at their moduli. Now and then
    // a tick carries garbage instead.
    task automatic run_phase(input int count);
        logic [DATA_W-1:0] t_now;
        logic [DATA_W-1:0] p_now;
        logic [DATA_W-1:0] p_rate;
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] p;
        int                k;
        t_now  = '0;
        p_now  = '0;
        p_rate = '0;
        for (k = 0; k < count; k++)
        begin
            if (k == 0 || $urandom_range(0, 39) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       p_rate = $urandom_range(0, 40);
                    1:       p_rate = $urandom_range(0, 3000);
                    default: p_rate = $urandom_range(0, 300000);
                endcase
                t_now = start_point(time_mod);
                p_now = start_point(pulse_mod);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        t = $urandom;
                        p = $urandom;
                    end
                    1:
                    begin
                        t = t_now;
                        p = $urandom;
                    end
                    default:
                    begin
                        t = $urandom;
                        p = p_now;
                    end
                endcase
            end
            else
            begin
                t_now = wrap_add(t_now, $urandom_range(9, 11), time_mod);
                p_now = wrap_add(p_now, p_rate + $urandom_range(0, p_rate / 4), pulse_mod);
                t     = t_now;
                p     = p_now;
            end
            send_tick(t, p, 1'b0, '0);
        end
    endtask

    function automatic script_row_t tick_row(input logic [DATA_W-1:0] t,
                                             input logic [DATA_W-1:0] p,
                                             input logic chk,
                                             input logic [RPM_W-1:0] want);
        return '{ROW_TICK, REG_WIN_A, '0, t, p, chk, want};
    endfunction

    function automatic script_row_t cfg_row(input logic [REG_IDX_W-1:0] idx,
                                            input logic [DATA_W-1:0] value);
        return '{ROW_CFG, idx, value, '0, '0, 1'b0, '0};
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts, and the check of every result
    // ------------------------------------------------------------------

    initial
    begin : sink_pacing
        int burst;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && rst_n && $urandom_range(1, 400) <= idle_pct)
            begin
                burst = $urandom_range(1, 13);
                out_stall <= 1'b1;
                repeat (burst)
                    @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        logic [RPM_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rpm_pending.size() == 0)
            begin
                flag_error($sformatf("rpm %0d arrived with nothing outstanding", rpm));
            end
            else
            begin
                want = rpm_pending.pop_front();
                if (rpm !== want)
                    flag_error($sformatf("rpm is %0d, expected %0d", rpm, want));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        script_row_t script [SCRIPT_ROWS];
        int          n;
        int          ph;

        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        time_ms     <= '0;
        pulse_total <= '0;
        clear_model();

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, from reset values (a=1, b=10, c=50, d=100, one pulse, ppr 1).
        script = '{
            // first tick: every tail is an unwritten entry, no pulses yet
            tick_row(32'd10, 32'd0, 1'b1, 16'd0),
            // 1000 pulses in 10 ms saturates
            tick_row(32'd20, 32'd1000, 1'b1, 16'd65535),
            // both counters at full scale: a quotient is 0, b sees one pulse per ms
            tick_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'd60000),
            // both counters roll over to zero: no pulses in any window
            tick_row(32'd0, 32'd0, 1'b1, 16'd0),
            // fewer pulses than ms: integer quotient 0 everywhere
            tick_row(32'd10, 32'd5, 1'b1, 16'd0),
            // no pulses per rev: no division, rpm 0
            cfg_row(REG_PPR, 32'd0),
            tick_row(32'd30, 32'd3000, 1'b1, 16'd0),
            // zero-length window a yields 0, b decides: 100 * (60000 / 255)
            cfg_row(REG_PPR, 32'd255),
            cfg_row(REG_WIN_A, 32'd0),
            tick_row(32'd40, 32'd4000, 1'b1, 16'd23500),
            // pulse floor above anything seen
            cfg_row(REG_MIN_PULSE, 32'd65535),
            tick_row(32'd50, 32'd5000, 1'b1, 16'd0),
            // old values above the modulus: wrapped difference clamps to 0
            cfg_row(REG_MIN_PULSE, 32'd0),
            cfg_row(REG_TIME_WRAP, 32'd5),
            cfg_row(REG_PULSE_WRAP, 32'd1),
            cfg_row(REG_WIN_A, 32'd1),
            tick_row(32'd3, 32'd2, 1'b1, 16'd0),
            // plain step, then a time wrap at 100 ms
            cfg_row(REG_TIME_WRAP, 32'd100),
            cfg_row(REG_PULSE_WRAP, 32'hFFFF_FFFF),
            tick_row(32'd95, 32'd100, 1'b1, 16'd235),
            tick_row(32'd5, 32'd1000, 1'b1, 16'd21150),
            // pulse counter wraps at 1000
            cfg_row(REG_PULSE_WRAP, 32'd1000),
            tick_row(32'd15, 32'd300, 1'b1, 16'd7050)
        };

        idle_pct = 20;
        for (n = 0; n < SCRIPT_ROWS; n++)
        begin
            if (script[n].kind == ROW_CFG)
            begin
                settle_idle();
                write_reg(script[n].ridx, script[n].rval);
            end
            else
            begin
                send_tick(script[n].t, script[n].p, script[n].chk, script[n].want);
            end
        end

        // Random phases, each under its own register setting.
        for (ph = 0; ph < PHASES; ph++)
        begin
            settle_idle();
            calm = (ph == PHASES - 1);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 50;
            endcase
            if (calm)
                idle_pct = 0;
            apply_setting(ph);
            run_phase(TICKS_PER_PHASE);
        end

        // Drain, then watch a while longer for stray results.
        settle_idle();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
